// ===== design/id3_pkg.sv =====
package id3_pkg;

  // Limits of the extractor.
  localparam int TITLE_MAX  = 64;
  localparam int ARTIST_MAX = 64;
  localparam int SCAN_BYTES = 8192;

  // The byte position must be able to hold the scan limit itself.
  localparam int POS_W   = $clog2(SCAN_BYTES + 1);
  localparam int HDR_LEN = 10;
  localparam int FILL_W  = $clog2(HDR_LEN);

  // Result queue geometry, counted in per-byte result groups.
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  localparam logic [7:0] TITLE_CAP  = 8'(TITLE_MAX - 1);
  localparam logic [7:0] ARTIST_CAP = 8'(ARTIST_MAX - 1);

  // ASCII codes used to recognize the tag and frame identifiers.
  localparam logic [7:0] CH_I    = 8'h49;
  localparam logic [7:0] CH_D    = 8'h44;
  localparam logic [7:0] CH_T    = 8'h54;
  localparam logic [7:0] CH_P    = 8'h50;
  localparam logic [7:0] CH_E    = 8'h45;
  localparam logic [7:0] CH_1    = 8'h31;
  localparam logic [7:0] CH_2    = 8'h32;
  localparam logic [7:0] CH_3    = 8'h33;
  localparam logic [7:0] MIN_VER = 8'd3;

  // Result kinds.
  localparam logic [1:0] KIND_TITLE   = 2'd0;
  localparam logic [1:0] KIND_ARTIST  = 2'd1;
  localparam logic [1:0] KIND_SUMMARY = 2'd2;

  // Parse status codes.
  localparam logic [1:0] STAT_OK      = 2'd0;
  localparam logic [1:0] STAT_NO_TAG  = 2'd1;
  localparam logic [1:0] STAT_OLD_VER = 2'd2;

  typedef enum logic [1:0] {
    PH_TAGHDR,
    PH_FRAMEHDR,
    PH_BODY,
    PH_DONE
  } phase_t;

  typedef enum logic [1:0] {
    TGT_NONE,
    TGT_TITLE,
    TGT_ARTIST
  } target_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       is_last;
  } req_t;

  typedef struct packed {
    logic [1:0]  item_kind;
    logic [7:0]  text_char;
    logic [7:0]  text_index;
    logic [28:0] data_start;
    logic [1:0]  status;
    logic        last_result;
  } res_t;

  // Results caused by one input byte: one or two of them.
  typedef struct packed {
    logic two;
    res_t first;
    res_t second;
  } res_pair_t;

endpackage

// ===== design/id3_parse.sv =====
module id3_parse
  import id3_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_ready,
  input  req_t              req,
  input  logic [QCNT_W-1:0] q_count,
  output logic              push,
  output res_pair_t         push_data
);

  typedef struct packed {
    phase_t                 phase;
    logic [POS_W-1:0]       pos;
    logic [HDR_LEN-2:0][7:0] hdr;
    logic [FILL_W-1:0]      fill;
    logic [28:0]            tag_len;
    logic [31:0]            left;
    target_t                target;
    logic [7:0]             count;
    logic [7:0]             limit;
    logic [1:0]             status;
    logic                   past_enc;
  } parse_state_t;

  localparam parse_state_t RESET_STATE = '{
    phase:    PH_TAGHDR,
    pos:      '0,
    hdr:      '0,
    fill:     '0,
    tag_len:  '0,
    left:     '0,
    target:   TGT_NONE,
    count:    '0,
    limit:    '0,
    status:   STAT_OK,
    past_enc: 1'b0
  };

  logic         in_valid;
  req_t         in_req;
  parse_state_t st;
  parse_state_t st_next;

  // Chooses between another frame header and the end of the walk.
  function automatic phase_t walk_on(input logic [POS_W-1:0] p, input logic [28:0] tl);
    if (29'(p) < tl && 32'(p) < 32'(SCAN_BYTES)) begin
      return PH_FRAMEHDR;
    end
    return PH_DONE;
  endfunction

  // There is always room for the group of the item now being processed.
  assign req_ready = (QCNT_W'(q_count) + QCNT_W'(in_valid)) < QCNT_W'(QDEPTH);

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      st       <= RESET_STATE;
    end else begin
      in_valid <= req_valid & req_ready;
      if (in_valid) begin
        st <= st_next;
      end
    end
    if (req_valid & req_ready) begin
      in_req <= req;
    end
  end

  always_comb begin
    logic [HDR_LEN-1:0][7:0] h;
    logic [7:0]              b;
    logic [31:0]             fsz;
    logic [7:0]              cap;
    logic                    emit;
    res_t                    chr;
    res_t                    sum;

    b       = in_req.data_byte;
    st_next = st;
    h       = '0;
    fsz     = '0;
    cap     = '0;
    emit    = 1'b0;
    chr     = '0;
    sum     = '0;

    if (st.pos < POS_W'(SCAN_BYTES)) begin
      st_next.pos = st.pos + POS_W'(1);
      case (st.phase)
        PH_TAGHDR, PH_FRAMEHDR: begin
          if (st.fill == FILL_W'(HDR_LEN - 1)) begin
            for (int i = 0; i < HDR_LEN - 1; i++) begin
              h[i] = st.hdr[i];
            end
            h[HDR_LEN-1] = b;
            st_next.fill = '0;
            if (st.phase == PH_TAGHDR) begin
              if (h[0] != CH_I || h[1] != CH_D || h[2] != CH_3) begin
                st_next.tag_len = '0;
                st_next.status  = STAT_NO_TAG;
                st_next.phase   = PH_DONE;
              end else begin
                // Size bytes are combined without dropping their top bits.
                st_next.tag_len = {h[6], 21'b0} | {7'b0, h[7], 14'b0} |
                                  {14'b0, h[8], 7'b0} | {21'b0, h[9]};
                if (h[3] < MIN_VER) begin
                  st_next.status = STAT_OLD_VER;
                  st_next.phase  = PH_DONE;
                end else begin
                  st_next.status = STAT_OK;
                  st_next.phase  = walk_on(st_next.pos, st_next.tag_len);
                end
              end
            end else begin
              fsz = {h[4], h[5], h[6], h[7]};
              st_next.target = TGT_NONE;
              if (h[0] == CH_T && ((h[1] == CH_T && h[2] == CH_2) ||
                  (h[1] == CH_I && h[2] == CH_T && h[3] == CH_2))) begin
                st_next.target = TGT_TITLE;
                cap            = TITLE_CAP;
              end else if (h[0] == CH_T && h[1] == CH_P && (h[2] == CH_1 ||
                           (h[2] == CH_E && h[3] == CH_1))) begin
                st_next.target = TGT_ARTIST;
                cap            = ARTIST_CAP;
              end
              st_next.limit = '0;
              if (fsz != '0) begin
                st_next.limit = ((fsz - 32'd1) < {24'b0, cap}) ? 8'(fsz - 32'd1) : cap;
              end
              st_next.count    = '0;
              st_next.past_enc = 1'b0;
              st_next.left     = fsz;
              if (fsz == '0) begin
                st_next.phase = walk_on(st_next.pos, st.tag_len);
              end else begin
                st_next.phase = PH_BODY;
              end
            end
          end else begin
            st_next.hdr[st.fill] = b;
            st_next.fill         = st.fill + FILL_W'(1);
          end
        end
        PH_BODY: begin
          if (!st.past_enc) begin
            st_next.past_enc = 1'b1;
          end else if (st.target != TGT_NONE && st.count < st.limit) begin
            if (b == 8'd0) begin
              st_next.target = TGT_NONE;
            end else begin
              emit             = 1'b1;
              chr.item_kind    = (st.target == TGT_TITLE) ? KIND_TITLE : KIND_ARTIST;
              chr.text_char    = b;
              chr.text_index   = st.count;
              st_next.count    = st.count + 8'd1;
            end
          end
          st_next.left = st.left - 32'd1;
          if (st.left == 32'd1) begin
            st_next.phase = walk_on(st_next.pos, st.tag_len);
          end
        end
        default: begin
        end
      endcase
    end

    sum.item_kind   = KIND_SUMMARY;
    sum.last_result = 1'b1;
    if (st_next.phase == PH_TAGHDR) begin
      sum.status = STAT_NO_TAG;
    end else begin
      sum.data_start = st_next.tag_len;
      sum.status     = st_next.status;
    end

    push_data = '0;
    push      = in_valid & (emit | in_req.is_last);
    if (emit) begin
      push_data.first  = chr;
      push_data.second = sum;
      push_data.two    = in_req.is_last;
    end else begin
      push_data.first = sum;
    end

    // The buffer ends here; the next byte starts a new file.
    if (in_req.is_last) begin
      st_next = RESET_STATE;
    end
  end

endmodule

// ===== design/id3_res_queue.sv =====
module id3_res_queue
  import id3_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  res_pair_t         push_data,
  output logic [QCNT_W-1:0] count,
  output logic              res_valid,
  input  logic              res_ready,
  output res_t              res
);

  res_pair_t [QDEPTH-1:0] slots;
  logic [QPTR_W-1:0]      wr_ptr;
  logic [QPTR_W-1:0]      rd_ptr;
  logic                   sub;
  logic                   pop;
  res_pair_t              head;

  assign head      = slots[rd_ptr];
  assign res_valid = (count != '0);
  assign res       = sub ? head.second : head.first;
  // A group leaves the queue once its last result has been taken.
  assign pop       = res_valid & res_ready & (~head.two | sub);

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
      sub    <= 1'b0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
        sub    <= 1'b0;
      end else if (res_valid & res_ready) begin
        sub <= 1'b1;
      end
      count <= count + QCNT_W'(push) - QCNT_W'(pop);
    end
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

endmodule

// ===== design/id3v2_tag_text_extractor.sv =====
// ID3v2 tag text extractor.
// The request channel (req_valid, req_ready, req) carries the file one byte
// per request from offset 0, with is_last set on the final byte of the
// buffer. The result channel (res_valid, res_ready, res) returns title and
// artist characters with their index, and after the last byte one summary
// with the parse status and the audio data start.
// A request accepted at a clock edge is captured in the input register of
// the parse stage and parsed there, and its results are then registered
// into the result queue, whose count drives res_valid. One byte is taken in
// every cycle; the only limit is the result queue of four entries, each
// entry holding the one or two results of a single byte. A byte that
// yields a character and is also the last one occupies the result channel
// for two transfers.
// When the receiver stalls, results wait in the queue and req_ready drops
// once the queue and the parse stage together could not take another byte.
// Synchronous reset empties the queue and the parse stage and puts the
// parser back at the tag header; the same return to the header happens on
// its own after every last byte.
module id3v2_tag_text_extractor
  import id3_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_ready,
  input  req_t req,
  output logic res_valid,
  input  logic res_ready,
  output res_t res
);

  logic [QCNT_W-1:0] q_count;
  logic              push;
  res_pair_t         push_data;

  // Input register, header and frame walk, text copy.
  id3_parse u_parse (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .q_count   (q_count),
    .push      (push),
    .push_data (push_data)
  );

  // Result register stage: groups of results wait here for the receiver.
  id3_res_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .count     (q_count),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

endmodule

// ===== bench/id3_extract_checker.sv =====
module id3_extract_checker
  import id3_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  input  logic req_ready,
  input  req_t req,
  input  logic res_valid,
  input  logic res_ready,
  input  res_t res,
  output int   fail_count,
  output int   pending,
  output int   n_bytes,
  output int   n_title,
  output int   n_artist,
  output int   n_summary,
  output int   n_no_tag,
  output int   n_old_ver
);

  // Parser state, tracked independently of the block.
  phase_t      phase;
  int unsigned pos;
  logic [7:0]  hdr_buf [HDR_LEN];
  int unsigned fill;
  logic [28:0] tag_len;
  logic [31:0] body_left;
  target_t     target;
  int unsigned text_cnt;
  logic [31:0] text_lim;
  logic [1:0]  parse_stat;
  bit          enc_seen;

  res_t expected_q[$];
  res_t want;

  function automatic void clear_parser();
    phase = PH_TAGHDR;
    pos = 0;
    foreach (hdr_buf[i]) hdr_buf[i] = '0;
    fill = 0;
    tag_len = '0;
    body_left = '0;
    target = TGT_NONE;
    text_cnt = 0;
    text_lim = '0;
    parse_stat = STAT_OK;
    enc_seen = 1'b0;
  endfunction

  // Move on to the next frame header if it still starts inside the tag.
  function automatic void seek_frame();
    if (pos < tag_len && pos < SCAN_BYTES) begin
      phase = PH_FRAMEHDR;
      fill = 0;
    end else begin
      phase = PH_DONE;
    end
  endfunction

  function automatic void start_frame();
    logic [31:0] fsz;
    logic [31:0] cap;
    fsz = {hdr_buf[4], hdr_buf[5], hdr_buf[6], hdr_buf[7]};
    cap = '0;
    target = TGT_NONE;
    if (hdr_buf[0] == CH_T && ((hdr_buf[1] == CH_T && hdr_buf[2] == CH_2) ||
        (hdr_buf[1] == CH_I && hdr_buf[2] == CH_T && hdr_buf[3] == CH_2))) begin
      target = TGT_TITLE;
      cap = TITLE_MAX - 1;
    end else if (hdr_buf[0] == CH_T && hdr_buf[1] == CH_P && (hdr_buf[2] == CH_1 ||
                 (hdr_buf[2] == CH_E && hdr_buf[3] == CH_1))) begin
      target = TGT_ARTIST;
      cap = ARTIST_MAX - 1;
    end
    text_lim = '0;
    if (fsz != 0) text_lim = (fsz - 1 < cap) ? fsz - 1 : cap;
    text_cnt = 0;
    enc_seen = 1'b0;
    body_left = fsz;
    if (fsz == 0) seek_frame();
    else phase = PH_BODY;
  endfunction

  function automatic void start_tag();
    logic [31:0] raw;
    if (hdr_buf[0] != CH_I || hdr_buf[1] != CH_D || hdr_buf[2] != CH_3) begin
      tag_len = '0;
      parse_stat = STAT_NO_TAG;
      phase = PH_DONE;
      return;
    end
    // The size bytes are combined as they come, bit 7 included.
    raw = ({24'd0, hdr_buf[6]} << 21) | ({24'd0, hdr_buf[7]} << 14) |
          ({24'd0, hdr_buf[8]} << 7) | {24'd0, hdr_buf[9]};
    tag_len = raw[28:0];
    if (hdr_buf[3] < MIN_VER) begin
      parse_stat = STAT_OLD_VER;
      phase = PH_DONE;
      return;
    end
    parse_stat = STAT_OK;
    seek_frame();
  endfunction

  function automatic void parse_byte(req_t r);
    if (pos < SCAN_BYTES) begin
      pos++;
      case (phase)
        PH_TAGHDR, PH_FRAMEHDR: begin
          if (fill < HDR_LEN) hdr_buf[fill] = r.data_byte;
          fill++;
          if (fill >= HDR_LEN) begin
            if (phase == PH_TAGHDR) start_tag();
            else start_frame();
          end
        end
        PH_BODY: begin
          if (!enc_seen) begin
            enc_seen = 1'b1;
          end else if (target != TGT_NONE && text_cnt < text_lim) begin
            if (r.data_byte == 8'h00) begin
              target = TGT_NONE;
            end else begin
              expected_q.push_back(res_t'{
                item_kind: (target == TGT_TITLE) ? KIND_TITLE : KIND_ARTIST,
                text_char: r.data_byte, text_index: 8'(text_cnt),
                data_start: '0, status: STAT_OK, last_result: 1'b0});
              text_cnt++;
            end
          end
          body_left--;
          if (body_left == 0) seek_frame();
        end
        default: ;
      endcase
    end
    if (r.is_last) begin
      expected_q.push_back(res_t'{
        item_kind: KIND_SUMMARY, text_char: 8'h00, text_index: 8'h00,
        data_start: (phase == PH_TAGHDR) ? 29'd0 : tag_len,
        status: (phase == PH_TAGHDR) ? STAT_NO_TAG : parse_stat,
        last_result: 1'b1});
      clear_parser();
    end
  endfunction

  function automatic void note_failure(string what, res_t exp_res, res_t got);
    fail_count++;
    if (fail_count <= 10) begin
      $display("Mismatch (%s): expected kind %0d char %02h idx %0d start %0d status %0d last %0d",
               what, exp_res.item_kind, exp_res.text_char, exp_res.text_index,
               exp_res.data_start, exp_res.status, exp_res.last_result);
      $display("                got      kind %0d char %02h idx %0d start %0d status %0d last %0d",
               got.item_kind, got.text_char, got.text_index, got.data_start, got.status,
               got.last_result);
    end
  endfunction

  function automatic void check_result(res_t got);
    if (expected_q.size() == 0) begin
      note_failure("no result pending", '0, got);
      return;
    end
    want = expected_q.pop_front();
    if (got.item_kind !== want.item_kind || got.text_char !== want.text_char ||
        got.text_index !== want.text_index || got.data_start !== want.data_start ||
        got.status !== want.status || got.last_result !== want.last_result)
      note_failure("field differs", want, got);
    case (want.item_kind)
      KIND_TITLE:  n_title++;
      KIND_ARTIST: n_artist++;
      default: begin
        n_summary++;
        if (want.status == STAT_NO_TAG) n_no_tag++;
        if (want.status == STAT_OLD_VER) n_old_ver++;
      end
    endcase
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      clear_parser();
      expected_q.delete();
      fail_count = 0;
      n_bytes = 0;
      n_title = 0;
      n_artist = 0;
      n_summary = 0;
      n_no_tag = 0;
      n_old_ver = 0;
      pending <= 0;
    end else begin
      // A result never stems from a request taken at the same edge.
      if (res_valid && res_ready) check_result(res);
      if (req_valid && req_ready) begin
        n_bytes++;
        parse_byte(req);
      end
      pending <= expected_q.size();
    end
  end

endmodule

// ===== bench/id3v2_tag_text_extractor_tb.sv =====
module id3v2_tag_text_extractor_tb;
  import id3_pkg::*;

  // Number of random bytes to send after the directed buffers.
  localparam int RANDOM_BYTES = 1600;
  // Percentage of cycles in which either side holds back.
  localparam int IDLE_PCT = 18;
  // Cycles without any request or result moving before the run is abandoned.
  localparam int STALL_LIMIT = 2000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_ready;
  req_t req = '0;
  logic res_valid;
  logic res_ready = 1'b0;
  res_t res;

  // While set, neither the sender nor the receiver inserts idle cycles.
  logic calm = 1'b0;

  int fail_count;
  int pending;
  int n_bytes;
  int n_title;
  int n_artist;
  int n_summary;
  int n_no_tag;
  int n_old_ver;
  int quiet_cycles = 0;
  int bytes_sent = 0;
  int files_sent = 0;

  // The buffer being assembled; it is sent as one file from offset 0.
  logic [7:0] file_q[$];

  id3v2_tag_text_extractor uut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  id3_extract_checker extract_chk (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req_valid),
    .req_ready  (req_ready),
    .req        (req),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .res        (res),
    .fail_count (fail_count),
    .pending    (pending),
    .n_bytes    (n_bytes),
    .n_title    (n_title),
    .n_artist   (n_artist),
    .n_summary  (n_summary),
    .n_no_tag   (n_no_tag),
    .n_old_ver  (n_old_ver)
  );

  always #6 clk = ~clk;

  // The receiver stalls at random, except during the calm stretch.
  always @(posedge clk) begin
    if (rst) begin
      res_ready <= 1'b0;
    end else begin
      res_ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  // Watchdog: any accepted request or result restarts the count.
  always @(posedge clk) begin
    if (rst || (req_valid && req_ready) || (res_valid && res_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("Watchdog: nothing moved for %0d cycles, %0d results still pending",
               STALL_LIMIT, pending);
      $display("CHECKS FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Offers one byte, after a random number of idle cycles, and returns at
  // the edge where the request is taken. Handshake signals are read right
  // after the edge, so they still hold the values the block saw at it.
  task automatic send_byte(input logic [7:0] value, input logic last);
    while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid <= 1'b1;
    req <= req_t'{data_byte: value, is_last: last};
    do @(posedge clk); while (!req_ready);
    bytes_sent++;
  endtask

  task automatic send_file();
    foreach (file_q[i]) send_byte(file_q[i], i == file_q.size() - 1);
    file_q.delete();
    files_sent++;
  endtask

  // Stops sending and waits until every predicted result has come back.
  task automatic wait_drained();
    req_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  function automatic void push_rand(int unsigned count);
    repeat (count) file_q.push_back(8'($urandom));
  endfunction

  // Appends one frame: a 10-byte header and, unless the size is absurd, its
  // whole body. Text frames get an encoding byte and mostly non-NUL text, at
  // times with a NUL in the middle. Sizes around the text limit check that
  // copying stops at the limit. A huge size leaves the frame open to the
  // end of the buffer, so nothing after it is parsed.
  function automatic void add_frame(input bit allow_huge, output bit runaway);
    logic [31:0] id;
    logic [31:0] fsz;
    int unsigned pick;
    int unsigned nul_at;
    int unsigned k;
    pick = $urandom_range(0, 9);
    case (pick)
      0, 1: id = {CH_T, CH_I, CH_T, CH_2};
      2:    id = {CH_T, CH_T, CH_2, 8'($urandom)};
      3, 4: id = {CH_T, CH_P, CH_E, CH_1};
      5:    id = {CH_T, CH_P, CH_1, 8'($urandom)};
      6: begin
        // One character away from a text frame id.
        id = ($urandom_range(0, 1) != 0) ? {CH_T, CH_I, CH_T, CH_2} : {CH_T, CH_P, CH_E, CH_1};
        id[8 * $urandom_range(0, 3) +: 8] = 8'($urandom);
      end
      default: id = $urandom;
    endcase
    pick = $urandom_range(0, 99);
    if (pick < 8) fsz = 0;
    else if (allow_huge && pick < 12) fsz = $urandom | 32'h0000_4000;
    else if (pick < 32) fsz = $urandom_range(TITLE_MAX - 2, TITLE_MAX + 20);
    else fsz = $urandom_range(1, 24);
    file_q.push_back(id[31:24]);
    file_q.push_back(id[23:16]);
    file_q.push_back(id[15:8]);
    file_q.push_back(id[7:0]);
    file_q.push_back(fsz[31:24]);
    file_q.push_back(fsz[23:16]);
    file_q.push_back(fsz[15:8]);
    file_q.push_back(fsz[7:0]);
    push_rand(2);
    runaway = (fsz > 32'd1024);
    if (runaway) begin
      push_rand($urandom_range(0, 20));
      return;
    end
    if (fsz != 0) begin
      file_q.push_back(8'($urandom));
      nul_at = ($urandom_range(0, 99) < 15) ? $urandom_range(1, fsz) : fsz;
      for (k = 1; k < fsz; k++)
        file_q.push_back((k == nul_at) ? 8'h00 : 8'($urandom_range(1, 255)));
    end
  endfunction

  // Builds a complete file that starts with an ID3 tag. The size field
  // normally matches the frames plus padding, whose zero bytes read as
  // frames of size zero. Sometimes it is taken raw from random bytes, which
  // may have bit 7 set, or it ends inside the frames so that a frame header
  // may straddle the tag end. Some files are cut off before the tag ends.
  // A nonzero min_body forces a tag at least that long.
  function automatic void add_tag(input int unsigned min_body);
    logic [31:0] tsz;
    int unsigned frames;
    int unsigned body;
    int unsigned pick;
    int unsigned cut;
    bit runaway;
    file_q.push_back(CH_I);
    file_q.push_back(CH_D);
    file_q.push_back(CH_3);
    file_q.push_back(($urandom_range(0, 99) < 85) ? 8'($urandom_range(3, 4))
                                                  : 8'($urandom_range(3, 255)));
    push_rand(6);
    frames = $urandom_range(1, 5);
    runaway = 1'b0;
    while (!runaway && (frames != 0 || file_q.size() < min_body)) begin
      add_frame(min_body == 0, runaway);
      if (frames != 0) frames--;
    end
    repeat ($urandom_range(0, 12)) file_q.push_back(8'h00);
    body = file_q.size() - HDR_LEN;
    pick = (min_body == 0) ? $urandom_range(0, 99) : 99;
    if (pick >= 15) begin
      tsz = (pick < 25) ? $urandom_range(0, body) : body;
      file_q[6] = {1'b0, tsz[27:21]};
      file_q[7] = {1'b0, tsz[20:14]};
      file_q[8] = {1'b0, tsz[13:7]};
      file_q[9] = {1'b0, tsz[6:0]};
    end
    push_rand($urandom_range(0, 8));
    if (min_body == 0 && $urandom_range(0, 99) < 15) begin
      cut = $urandom_range(1, file_q.size());
      while (file_q.size() > cut) void'(file_q.pop_back());
    end
  endfunction

  // Picks one random file: mostly well-formed tags, the rest noise, files
  // that end inside the tag header, and tags with an old major version.
  function automatic void make_file();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 8) begin
      push_rand($urandom_range(1, 30));
    end else if (pick < 14) begin
      file_q.push_back(CH_I);
      file_q.push_back(CH_D);
      file_q.push_back(CH_3);
      push_rand($urandom_range(0, 6));
    end else if (pick < 20) begin
      file_q.push_back(CH_I);
      file_q.push_back(CH_D);
      file_q.push_back(CH_3);
      file_q.push_back(8'($urandom_range(0, 2)));
      push_rand(6 + $urandom_range(0, 10));
    end else begin
      add_tag(0);
    end
  endfunction

  initial begin
    int unsigned file_no;
    int unsigned base;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // A one-byte buffer: the header never completes, so no tag is reported.
    file_q.push_back(8'h00);
    send_file();
    // Major version 2 with every size bit set: an error summary that still
    // carries the largest possible data start.
    file_q = '{CH_I, CH_D, CH_3, 8'd2, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF};
    send_file();
    // A version 4 tag of length zero: no frame is walked, and the trailing
    // bytes, with all bit patterns at the extremes, are plain audio.
    file_q = '{CH_I, CH_D, CH_3, 8'd4, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
               8'hFF, 8'h80, 8'h01, 8'h7F};
    send_file();

    // Random files. Files 4 to 7 run with no idling on either side, and
    // every fifth file waits for the result channel to empty first.
    file_no = 0;
    base = bytes_sent;
    while (bytes_sent < base + RANDOM_BYTES) begin
      calm <= (file_no >= 4 && file_no < 8);
      if (file_no % 5 == 4) wait_drained();
      make_file();
      send_file();
      file_no++;
    end

    wait_drained();
    repeat (20) @(posedge clk);
    $display("Sent %0d bytes in %0d buffers; checked %0d title and %0d artist characters",
             n_bytes, files_sent, n_title, n_artist);
    $display("and %0d summaries (%0d without a tag, %0d with an old version)",
             n_summary, n_no_tag, n_old_ver);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("%0d results did not match", fail_count);
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
